/* src/knuth_interval_dp_cut_cost_assert.svh */
// Assertion macros for the interval DP cut cost block.
// Included by the top level; no other dependencies.
`ifndef KNUTH_INTERVAL_DP_CUT_COST_ASSERT_SVH
`define KNUTH_INTERVAL_DP_CUT_COST_ASSERT_SVH
`ifndef SYNTHESIS
`define KIDCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KIDCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KIDCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KIDCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/kidcc_pkg.sv */
// Shared constants and helpers for the interval DP cut cost block.
// No dependencies.
`default_nettype none
package kidcc_pkg;
  localparam int unsigned COST_W   = 26;
  localparam int unsigned SUM_W    = COST_W + 2;
  localparam int unsigned OUT_DW   = ((COST_W + 7) / 8) * 8;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef logic [COST_W-1:0] cost_t;

  // a + b + c, saturating at COST_MAX
  function automatic cost_t sat_add3(cost_t a, cost_t b, cost_t c);
    logic [SUM_W-1:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    return (s > {2'b00, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
  endfunction
endpackage
`default_nettype wire

/* src/knuth_interval_dp_cut_cost.sv */
// Top level: Knuth-optimised interval DP over loaded cut positions.
// Depends on kidcc_pkg and knuth_interval_dp_cut_cost_assert.svh.
//
// Usage:
//   Slave stream carries one position word per beat (tdata[POS_BITS-1:0]),
//   tlast marks the final word, which holds the total length. Words beyond
//   MAX_SEGS are dropped and flagged. Master stream returns one word per
//   list: tdata[25:0] is the minimum total cost, tuser the overflow flag.
// Operation:
//   Loading accepts one word per cycle, but only in S_LOAD. After the last word
//   the DP runs on a single shared add/compare unit: it seeds the diagonal,
//   then per interval fetches, bounds and evaluates each candidate split
//   within the Knuth bounds, then registers the result. Work is set by the
//   split loop on the shared adder; cost and choice tables are dual-read
//   memories with registered read data.
// Reset: asynchronous active-low; clears the sequencer, the word count and
//   the overflow flag. Tables need no clearing: every entry is written
//   before it is read.
// Stall: the result sits in the output register; new words are accepted
//   meanwhile, but the next DP result waits until the old one is taken.
`default_nettype none
`include "knuth_interval_dp_cut_cost_assert.svh"
module knuth_interval_dp_cut_cost #(
  parameter int unsigned MAX_SEGS = 64,
  parameter int unsigned POS_BITS = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [POS_BITS-1:0] position, rest zero padding
  input  wire logic [((POS_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [25:0] total_cost, rest zero padding
  output logic [kidcc_pkg::OUT_DW-1:0]              m_axis_tdata,
  // [0] overflow
  output logic                                      m_axis_tuser
);
  import kidcc_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_SEGS + 1);
  localparam int unsigned AW    = $clog2(MAX_SEGS);
  localparam int unsigned TDEP  = 1 << (2 * AW);
  localparam int unsigned WW    = (POS_BITS > COST_W) ? POS_BITS : COST_W;

  typedef enum logic [2:0] {
    S_LOAD, S_INIT, S_FETCH, S_BOUNDS, S_EVAL, S_DRAIN, S_DONE
  } state_e;

  typedef logic [IW-1:0]     idx_t;
  typedef logic [2*AW-1:0]   taddr_t;

  function automatic taddr_t tab_addr(idx_t r, idx_t c);
    idx_t r1, c1;
    r1 = r - idx_t'(1);
    c1 = c - idx_t'(1);
    return {r1[AW-1:0], c1[AW-1:0]};
  endfunction

  // storage
  logic [POS_BITS-1:0] pos_mem [MAX_SEGS];
  cost_t               cost_mem [TDEP];
  idx_t                ch_mem [TDEP];

  // control
  state_e state_q;
  idx_t   count_q, n_q, j_q, i_q, k_q, lo_q, hi_q, best_k_q, cmp_k_q;
  logic   ovf_q, have_q, cmp_v_q;
  cost_t  w_q, best_q;
  logic   out_v_q, out_ovf_q;
  cost_t  out_cost_q;

  // memory read data
  logic [POS_BITS-1:0] pos_hi_q, pos_lo_q;
  idx_t                ch_a_q, ch_b_q;
  cost_t               cost_a_q, cost_b_q;

  // memory ports
  logic                pos_we;
  logic [AW-1:0]       pos_wa, pos_ra, pos_rb;
  logic                tab_we;
  taddr_t              tab_wa, ch_ra, ch_rb, cost_ra, cost_rb;
  cost_t               tab_wcost;
  idx_t                tab_wch;

  logic   in_acc, room;
  idx_t   j_m2, i_m1, lo_c, hi_c;
  logic [POS_BITS-1:0] pos_lo_v, diff;
  logic [WW-1:0]       diff_w;
  cost_t  w_c, cand, best_n;
  idx_t   best_k_n;
  logic   upd;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_LOAD);
  assign room          = (count_q < idx_t'(MAX_SEGS));

  assign j_m2 = j_q - idx_t'(2);
  assign i_m1 = i_q - idx_t'(1);

  assign pos_we = in_acc && room;
  assign pos_wa = count_q[AW-1:0];
  assign pos_ra = i_m1[AW-1:0];
  assign pos_rb = j_m2[AW-1:0];

  assign ch_ra   = tab_addr(j_q, i_m1);
  assign ch_rb   = tab_addr(j_q + idx_t'(1), i_q);
  assign cost_ra = tab_addr(j_q, k_q);
  assign cost_rb = tab_addr(k_q + idx_t'(1), i_q);

  // bounds on the split range
  always_comb begin
    lo_c = (ch_a_q < j_q) ? j_q : ch_a_q;
    if (lo_c > i_m1) lo_c = i_m1;
    hi_c = (ch_b_q > i_m1) ? i_m1 : ch_b_q;
    if (hi_c < lo_c) hi_c = lo_c;
  end

  // span cost, negative spans clamp to zero
  assign pos_lo_v = (j_q == idx_t'(1)) ? '0 : pos_lo_q;
  assign diff     = (pos_hi_q > pos_lo_v) ? (pos_hi_q - pos_lo_v) : '0;
  assign diff_w   = WW'(diff);
  assign w_c      = (diff_w > WW'(COST_MAX)) ? COST_MAX : diff_w[COST_W-1:0];

  // shared add/compare unit
  assign cand     = sat_add3(cost_a_q, cost_b_q, w_q);
  assign upd      = cmp_v_q && (!have_q || (cand < best_q));
  assign best_n   = upd ? cand : best_q;
  assign best_k_n = upd ? cmp_k_q : best_k_q;

  always_comb begin
    tab_we    = 1'b0;
    tab_wa    = tab_addr(k_q, k_q);
    tab_wcost = '0;
    tab_wch   = k_q;
    case (state_q)
      S_INIT: begin
        tab_we = 1'b1;
      end
      S_DRAIN: begin
        tab_we    = 1'b1;
        tab_wa    = tab_addr(j_q, i_q);
        tab_wcost = best_n;
        tab_wch   = best_k_n;
      end
      default: begin
        tab_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= s_axis_tdata[POS_BITS-1:0];
    pos_hi_q <= pos_mem[pos_ra];
    pos_lo_q <= pos_mem[pos_rb];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      cost_mem[tab_wa] <= tab_wcost;
      ch_mem[tab_wa]   <= tab_wch;
    end
    ch_a_q   <= ch_mem[ch_ra];
    ch_b_q   <= ch_mem[ch_rb];
    cost_a_q <= cost_mem[cost_ra];
    cost_b_q <= cost_mem[cost_rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      n_q       <= '0;
      j_q       <= '0;
      i_q       <= '0;
      k_q       <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      have_q    <= 1'b0;
      cmp_v_q   <= 1'b0;
      cmp_k_q   <= '0;
      w_q       <= '0;
      best_q    <= '0;
      best_k_q  <= '0;
      out_v_q   <= 1'b0;
      out_ovf_q <= 1'b0;
      out_cost_q <= '0;
    end else begin
      cmp_v_q <= (state_q == S_EVAL);
      cmp_k_q <= k_q;
      // in S_DONE the output register is reloaded below
      if (out_v_q && m_axis_tready && (state_q != S_DONE)) out_v_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (room) count_q <= count_q + idx_t'(1);
            else      ovf_q   <= 1'b1;
            if (s_axis_tlast) begin
              n_q     <= room ? count_q + idx_t'(1) : count_q;
              k_q     <= idx_t'(1);
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (k_q == n_q) begin
            best_q <= '0;
            j_q    <= idx_t'(1);
            i_q    <= idx_t'(2);
            state_q <= (n_q == idx_t'(1)) ? S_DONE : S_FETCH;
          end else begin
            k_q <= k_q + idx_t'(1);
          end
        end
        S_FETCH: begin
          state_q <= S_BOUNDS;
        end
        S_BOUNDS: begin
          lo_q    <= lo_c;
          hi_q    <= hi_c;
          k_q     <= lo_c;
          w_q     <= w_c;
          have_q  <= 1'b0;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (cmp_v_q) begin
            best_q   <= best_n;
            best_k_q <= best_k_n;
            have_q   <= 1'b1;
          end
          if (k_q == hi_q) state_q <= S_DRAIN;
          else             k_q     <= k_q + idx_t'(1);
        end
        S_DRAIN: begin
          best_q <= best_n;
          if (i_q == n_q) begin
            if (j_q == idx_t'(1)) begin
              state_q <= S_DONE;
            end else begin
              i_q     <= i_q - j_q + idx_t'(2);
              j_q     <= idx_t'(1);
              state_q <= S_FETCH;
            end
          end else begin
            j_q     <= j_q + idx_t'(1);
            i_q     <= i_q + idx_t'(1);
            state_q <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_v_q || m_axis_tready) begin
            out_v_q    <= 1'b1;
            out_cost_q <= best_q;
            out_ovf_q  <= ovf_q;
            count_q    <= '0;
            ovf_q      <= 1'b0;
            state_q    <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_DW'(out_cost_q);
  assign m_axis_tuser  = out_ovf_q;

  `KIDCC_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, count_q <= idx_t'(MAX_SEGS))
  `KIDCC_ASSERT_IMP(a_eval_k, clk_i, rst_ni, state_q == S_EVAL,
                    (k_q >= lo_q) && (k_q <= hi_q) && (hi_q < i_q))
  `KIDCC_ASSERT_IMP(a_interval, clk_i, rst_ni, state_q == S_FETCH,
                    (j_q < i_q) && (i_q <= n_q) && (j_q != idx_t'(0)))
  `KIDCC_ASSERT_NXT(a_drain_once, clk_i, rst_ni, state_q == S_DRAIN, state_q != S_DRAIN)

endmodule
`default_nettype wire
